### design/mprb_pkg.sv
`timescale 1ns / 1ps
// mprb_pkg: request/result types, operation and status codes for the
// multi-port receive ring buffer. No dependencies.
package mprb_pkg;

    localparam int CFG_REGS   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [2:0] {
        OP_PUT   = 3'd0,
        OP_READ  = 3'd1,
        OP_COUNT = 3'd2,
        OP_FLUSH = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_PARAM = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] port;
        logic [7:0] byte_in;
        logic [6:0] read_length;
    } t_req;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic [7:0] buffered_count;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    single_vld;
        t_result single_res;
        logic    byte_vld;
        logic    byte_last;
    } t_emit;

endpackage

### design/mprb_ring_mem.sv
`timescale 1ns / 1ps
// mprb_ring_mem: byte store for all ring buffers, one write and one
// registered read port. No dependencies.
module mprb_ring_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/mprb_ctrl.sv
`timescale 1ns / 1ps
// mprb_ctrl: size registers, per-port pointers, request decode, clearing
// pass and read sequencer. Depends on mprb_pkg.
module mprb_ctrl #(
    parameter int PORT_COUNT = 4,
    parameter int PORT_DEPTH = 256,
    parameter int MAX_READ   = 64,
    parameter int NP         = 4,
    parameter int AW         = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  mprb_pkg::t_req                     i_req,
    input  logic                               i_cfg_we,
    input  logic [mprb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mprb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_mem_we,
    output logic [AW-1:0]                      o_mem_waddr,
    output logic [7:0]                         o_mem_wdata,
    output logic [AW-1:0]                      o_mem_raddr,
    output mprb_pkg::t_emit                    o_emit
);
    import mprb_pkg::*;

    localparam int MD  = NP * PORT_DEPTH;
    localparam int PW  = $clog2(PORT_DEPTH);
    localparam int SW  = $clog2(PORT_DEPTH + 1);
    localparam int SX  = SW + 1;
    localparam int PIW = (NP > 1) ? $clog2(NP) : 1;

    t_state                r_state, n_state;
    logic [CFG_DATA_W-1:0] r_size [CFG_REGS];
    logic [CFG_DATA_W-1:0] n_size [CFG_REGS];
    logic [PW-1:0]         r_wp [NP];
    logic [PW-1:0]         n_wp [NP];
    logic [PW-1:0]         r_rp [NP];
    logic [PW-1:0]         n_rp [NP];
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic [PIW-1:0]        r_run_port, n_run_port;
    logic [PW-1:0]         r_run_ptr, n_run_ptr;
    logic [SW-1:0]         r_run_size, n_run_size;
    logic [6:0]            r_run_left, n_run_left;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_rd_last, n_rd_last;

    logic                  accept;
    logic                  port_ok;
    logic [PIW-1:0]        pidx;
    logic [SW-1:0]         sz;
    logic [SW-1:0]         cs;
    logic [PW-1:0]         w_ptr, r_ptr;
    logic [AW-1:0]         base_a;
    logic [SW-1:0]         v_nxt;
    logic [SX-1:0]         v_sum;
    logic [SW-1:0]         v_run_nxt;

    function automatic logic [SW-1:0] f_size(input logic [CFG_DATA_W-1:0] v);
        int unsigned s;
        s = 32'(v);
        if (s < 32'd2) s = 32'd2;
        if (s > 32'(PORT_DEPTH)) s = 32'(PORT_DEPTH);
        return SW'(s);
    endfunction

    assign busy    = (r_state != S_IDLE) || r_rd_vld;
    assign accept  = start && !busy;
    assign port_ok = (int'(i_req.port) < PORT_COUNT);
    assign pidx    = i_req.port[PIW-1:0];
    assign sz      = f_size(r_size[i_req.port]);
    assign cs      = f_size(i_cfg_data);
    assign w_ptr   = r_wp[pidx];
    assign r_ptr   = r_rp[pidx];
    assign base_a  = AW'(int'(pidx) * PORT_DEPTH);

    always_comb begin
        n_state      = r_state;
        n_size       = r_size;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_clr_addr   = r_clr_addr;
        n_run_port   = r_run_port;
        n_run_ptr    = r_run_ptr;
        n_run_size   = r_run_size;
        n_run_left   = r_run_left;
        n_rd_vld     = 1'b0;
        n_rd_last    = 1'b0;
        o_mem_we     = 1'b0;
        o_mem_waddr  = base_a + AW'(w_ptr);
        o_mem_wdata  = i_req.byte_in;
        o_mem_raddr  = AW'(int'(r_run_port) * PORT_DEPTH) + AW'(r_run_ptr);
        o_emit.single_vld = 1'b0;
        o_emit.single_res = '0;
        o_emit.byte_vld   = r_rd_vld;
        o_emit.byte_last  = r_rd_last;
        v_nxt        = SW'(w_ptr) + SW'(1);
        v_sum        = SX'(r_ptr) + SX'(i_req.read_length);
        v_run_nxt    = SW'(r_run_ptr) + SW'(1);

        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_addr;
                o_mem_wdata = '0;
                if (r_clr_addr == AW'(MD - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_RUN: begin
                n_rd_vld   = 1'b1;
                n_rd_last  = (r_run_left == 7'd1);
                n_run_left = r_run_left - 7'd1;
                n_run_ptr  = (v_run_nxt >= r_run_size) ? '0 : PW'(v_run_nxt);
                if (r_run_left == 7'd1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_req.operation)
                        OP_PUT: begin
                            if (port_ok) begin
                                o_mem_we    = 1'b1;
                                n_wp[pidx]  = (v_nxt >= sz) ? '0 : PW'(v_nxt);
                            end
                        end
                        OP_READ: begin
                            o_emit.single_res.last = 1'b1;
                            if (!port_ok || int'(i_req.read_length) >= int'(sz)
                                    || int'(i_req.read_length) > MAX_READ) begin
                                o_emit.single_vld        = 1'b1;
                                o_emit.single_res.status = ST_BAD_PARAM;
                            end else if (w_ptr == r_ptr) begin
                                o_emit.single_vld        = 1'b1;
                                o_emit.single_res.status = ST_EMPTY;
                            end else if (i_req.read_length == 7'd0) begin
                                o_emit.single_vld        = 1'b1;
                                o_emit.single_res.status = ST_OK;
                            end else begin
                                n_state    = S_RUN;
                                n_run_port = pidx;
                                n_run_ptr  = r_ptr;
                                n_run_size = sz;
                                n_run_left = i_req.read_length;
                                if (v_sum >= SX'(sz)) begin
                                    n_rp[pidx] = PW'(v_sum - SX'(sz));
                                end else begin
                                    n_rp[pidx] = PW'(v_sum);
                                end
                            end
                        end
                        OP_COUNT: begin
                            o_emit.single_vld      = 1'b1;
                            o_emit.single_res.last = 1'b1;
                            if (!port_ok) begin
                                o_emit.single_res.status = ST_BAD_PARAM;
                            end else if (w_ptr >= r_ptr) begin
                                o_emit.single_res.buffered_count =
                                    8'(SX'(w_ptr) - SX'(r_ptr));
                            end else begin
                                o_emit.single_res.buffered_count =
                                    8'(SX'(w_ptr) + SX'(sz) - SX'(r_ptr));
                            end
                        end
                        OP_FLUSH: begin
                            if (port_ok) begin
                                n_rp[pidx] = w_ptr;
                            end
                        end
                        OP_CLEAR: begin
                            if (port_ok) begin
                                n_rp[pidx] = '0;
                                n_wp[pidx] = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            for (int k = 0; k < CFG_REGS; k++) begin
                if (i_cfg_index == CFG_IDX_W'(k)) begin
                    n_size[k] = i_cfg_data;
                end
            end
            for (int k = 0; k < NP; k++) begin
                if (i_cfg_index == CFG_IDX_W'(k)) begin
                    if (SW'(r_wp[k]) >= cs) n_wp[k] = '0;
                    if (SW'(r_rp[k]) >= cs) n_rp[k] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_size     <= '{default: CFG_DATA_W'(256)};
            r_wp       <= '{default: '0};
            r_rp       <= '{default: '0};
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_size     <= n_size;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_rd_vld   <= n_rd_vld;
            r_rd_last  <= n_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_port <= n_run_port;
        r_run_ptr  <= n_run_ptr;
        r_run_size <= n_run_size;
        r_run_left <= n_run_left;
    end

endmodule

### design/multi_port_receive_ring_buffer.sv
`timescale 1ns / 1ps
// multi_port_receive_ring_buffer: top level, output register and wiring of
// the control and byte store. Depends on mprb_pkg, mprb_ctrl, mprb_ring_mem.
//
// Usage: a request (i_req) is taken at a clock edge where start is high and
// busy is low. Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) set
// the ring size of one port and are taken at once, at any edge.
// Results appear on o_res for one cycle each, marked by o_strobe; the
// receiver cannot stall, so each result must be taken in that cycle.
// Timing:
//   put, flush, clear  - no result; busy stays low.
//   count query, any single-result read - result in the cycle after accept.
//   read of n bytes    - busy until the last byte leaves the store; bytes
//                        come one per cycle, registered, the last flagged.
// Read rate is one byte per cycle, set by the single read port of the store.
// After reset the store is zeroed by a clearing pass over all
// min(PORT_COUNT,4)*PORT_DEPTH bytes (1024 by default) with busy high;
// pointers and size registers reset at once.
module multi_port_receive_ring_buffer #(
    parameter int PORT_COUNT = 4,
    parameter int PORT_DEPTH = 256,
    parameter int MAX_READ   = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  mprb_pkg::t_req                     i_req,
    output logic                               o_strobe,
    output mprb_pkg::t_result                  o_res,
    input  logic                               i_cfg_we,
    input  logic [mprb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mprb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mprb_pkg::*;

    localparam int NP = (PORT_COUNT > 4) ? 4 : PORT_COUNT;
    localparam int MD = NP * PORT_DEPTH;
    localparam int AW = $clog2(MD);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_q;
    t_emit         emit;
    logic          r_strobe;
    t_result       r_res;

    mprb_ctrl #(
        .PORT_COUNT (PORT_COUNT),
        .PORT_DEPTH (PORT_DEPTH),
        .MAX_READ   (MAX_READ),
        .NP         (NP),
        .AW         (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .o_emit      (emit)
    );

    mprb_ring_mem #(
        .DEPTH (MD),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= emit.single_vld | emit.byte_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.byte_vld) begin
            r_res.read_byte      <= mem_q;
            r_res.byte_valid     <= 1'b1;
            r_res.status         <= ST_OK;
            r_res.buffered_count <= '0;
            r_res.last           <= emit.byte_last;
        end else begin
            r_res <= emit.single_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

### design/mprb_checker.sv
`timescale 1ns / 1ps
// mprb_checker: port-level assertions for the ring buffer, bound to the top
// level. Depends on mprb_pkg and multi_port_receive_ring_buffer.
module mprb_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input mprb_pkg::t_req          i_req,
    input logic                    o_strobe,
    input mprb_pkg::t_result       o_res
);
    import mprb_pkg::*;

    // clearing pass holds off requests straight after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low after reset");

    // a run of read bytes is contiguous up to its last
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |=> o_strobe)
        else $error("gap inside read run");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.byte_valid |-> o_res.last)
        else $error("non-data result not last");

    a_put_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.operation == OP_PUT |=> !o_strobe)
        else $error("put produced a result");

    a_count_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.operation == OP_COUNT |=> o_strobe && o_res.last)
        else $error("count query not answered next cycle");

endmodule

bind multi_port_receive_ring_buffer mprb_checker u_mprb_checker (.*);
